>>> src/frs_pkg.sv
// ----------------------------------------------------------------------------
// frs_pkg
// Types and constants shared by the vblank frame release scheduler.
// ----------------------------------------------------------------------------
package frs_pkg;

   localparam int ID_WIDTH         = 16;
   localparam int TIME_WIDTH       = 63;
   localparam int STAMP_WIDTH      = 64;
   localparam int HZ_WIDTH         = 8;
   localparam int LEAD_WIDTH       = 3;
   localparam int INTERVAL_WIDTH   = 20;
   localparam int OFFSET_WIDTH     = LEAD_WIDTH + INTERVAL_WIDTH;
   localparam int DIV_STEP_WIDTH   = 5;
   localparam int CSR_INDEX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH   = 8;
   localparam int MAX_RESULTS      = 16;
   localparam int POP_COUNT_WIDTH  = 5;

   localparam int UsecPerSecInt    = 1000000;
   localparam int RefreshResetInt  = 60;
   localparam int LeadResetInt     = 3;
   localparam int IntervalResetInt = (UsecPerSecInt + RefreshResetInt / 2) / RefreshResetInt;

   localparam logic [INTERVAL_WIDTH-1:0]  USEC_PER_SEC     = INTERVAL_WIDTH'(UsecPerSecInt);
   localparam logic [HZ_WIDTH-1:0]        REFRESH_HZ_RESET = HZ_WIDTH'(RefreshResetInt);
   localparam logic [LEAD_WIDTH-1:0]      LEAD_RESET       = LEAD_WIDTH'(LeadResetInt);
   localparam logic [INTERVAL_WIDTH-1:0]  INTERVAL_RESET   = INTERVAL_WIDTH'(IntervalResetInt);
   localparam logic [OFFSET_WIDTH-1:0]    OFFSET_RESET     =
      OFFSET_WIDTH'(LeadResetInt * IntervalResetInt);
   localparam logic [DIV_STEP_WIDTH-1:0]  DIV_LAST_STEP    = DIV_STEP_WIDTH'(INTERVAL_WIDTH - 1);
   localparam logic [POP_COUNT_WIDTH-1:0] POP_LAST         = POP_COUNT_WIDTH'(MAX_RESULTS - 1);

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REFRESH_HZ   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LEAD_VBLANKS = 2'd1;

   localparam logic [2:0] OP_ENQUEUE = 3'd0;
   localparam logic [2:0] OP_TICK    = 3'd1;
   localparam logic [2:0] OP_FLUSH   = 3'd2;
   localparam logic [2:0] OP_PAUSE   = 3'd3;
   localparam logic [2:0] OP_RESUME  = 3'd4;

   typedef enum logic [1:0] {
      ACT_DROP   = 2'd0,
      ACT_POST   = 2'd1,
      ACT_REJECT = 2'd2
   } action_type;

   typedef struct packed {
      logic [2:0]            op;
      logic [ID_WIDTH-1:0]   frame_id;
      logic [TIME_WIDTH-1:0] time_us;
   } req_type;

   typedef struct packed {
      action_type          action;
      logic [ID_WIDTH-1:0] frame_id_out;
      logic                last;
   } rsp_type;

   typedef enum logic [2:0] {
      CMD_ENQUEUE,
      CMD_TICK,
      CMD_FLUSH,
      CMD_PAUSE,
      CMD_RESUME
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic [ID_WIDTH-1:0]    frame_id;
      logic [STAMP_WIDTH-1:0] stamp;
   } cmd_type;

   typedef struct packed {
      logic                    busy;
      logic [OFFSET_WIDTH-1:0] offset;
   } timing_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_TICK_READ,
      BK_TICK_CHECK,
      BK_TICK_POST,
      BK_FLUSH_READ,
      BK_FLUSH_EMIT
   } back_state_type;

endpackage

>>> src/frs_ram.sv
// ----------------------------------------------------------------------------
// frs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module frs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/frs_csr.sv
// ----------------------------------------------------------------------------
// frs_csr
// Configuration registers, refresh interval divider and deadline offset.
// ----------------------------------------------------------------------------
module frs_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [frs_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [frs_pkg::CSR_DATA_WIDTH-1:0]    csr_data,
   output frs_pkg::timing_type                   timing
);

   logic [frs_pkg::HZ_WIDTH-1:0]        hz_ff, hz_in;
   logic [frs_pkg::LEAD_WIDTH-1:0]      lead_ff, lead_in;
   logic [frs_pkg::INTERVAL_WIDTH-1:0]  interval_ff, interval_in;
   logic [frs_pkg::OFFSET_WIDTH-1:0]    offset_ff, offset_in;
   logic                                busy_ff, busy_in;
   logic                                settle_ff, settle_in;
   logic [frs_pkg::INTERVAL_WIDTH-1:0]  work_ff, work_in;
   logic [frs_pkg::HZ_WIDTH-1:0]        rem_ff, rem_in;
   logic [frs_pkg::DIV_STEP_WIDTH-1:0]  step_ff, step_in;
   logic                                write;
   logic [frs_pkg::HZ_WIDTH:0]          trial;
   logic                                qbit;

   assign csr_ready = !busy_ff;
   assign write     = csr_valid && csr_ready;

   always_comb begin
      hz_in       = hz_ff;
      lead_in     = lead_ff;
      interval_in = interval_ff;
      busy_in     = busy_ff;
      settle_in   = 1'b0;
      work_in     = work_ff;
      rem_in      = rem_ff;
      step_in     = step_ff;
      trial       = {rem_ff, work_ff[frs_pkg::INTERVAL_WIDTH-1]};
      qbit        = (trial >= {1'b0, hz_ff});
      offset_in   = frs_pkg::OFFSET_WIDTH'(lead_ff * interval_ff);

      if (busy_ff) begin
         rem_in  = qbit ? frs_pkg::HZ_WIDTH'(trial - {1'b0, hz_ff})
                        : frs_pkg::HZ_WIDTH'(trial);
         work_in = {work_ff[frs_pkg::INTERVAL_WIDTH-2:0], qbit};
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in     = 1'b0;
            settle_in   = 1'b1;
            interval_in = {work_ff[frs_pkg::INTERVAL_WIDTH-2:0], qbit};
         end
      end else if (write) begin
         settle_in = 1'b1;
         case (csr_index)
            frs_pkg::CSR_REFRESH_HZ: begin
               hz_in = csr_data[frs_pkg::HZ_WIDTH-1:0];
               if (csr_data[frs_pkg::HZ_WIDTH-1:0] == '0) begin
                  interval_in = '0;
               end else begin
                  busy_in = 1'b1;
                  rem_in  = '0;
                  step_in = frs_pkg::DIV_LAST_STEP;
                  work_in = frs_pkg::USEC_PER_SEC +
                            frs_pkg::INTERVAL_WIDTH'(csr_data[frs_pkg::HZ_WIDTH-1:1]);
               end
            end
            frs_pkg::CSR_LEAD_VBLANKS: begin
               lead_in = csr_data[frs_pkg::LEAD_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hz_ff       <= frs_pkg::REFRESH_HZ_RESET;
         lead_ff     <= frs_pkg::LEAD_RESET;
         interval_ff <= frs_pkg::INTERVAL_RESET;
         offset_ff   <= frs_pkg::OFFSET_RESET;
         busy_ff     <= 1'b0;
         settle_ff   <= 1'b0;
      end else begin
         hz_ff       <= hz_in;
         lead_ff     <= lead_in;
         interval_ff <= interval_in;
         offset_ff   <= offset_in;
         busy_ff     <= busy_in;
         settle_ff   <= settle_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

   assign timing.busy   = busy_ff || settle_ff;
   assign timing.offset = offset_ff;

endmodule

>>> src/frs_front.sv
// ----------------------------------------------------------------------------
// frs_front
// Accepts items, decodes the operation, forms tick deadlines and queues
// commands for the back end.
// ----------------------------------------------------------------------------
module frs_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  frs_pkg::req_type     req_item,
   input  frs_pkg::timing_type  timing,
   output logic                 cmd_valid,
   output frs_pkg::cmd_type     cmd,
   input  logic                 cmd_pop
);

   localparam int Slots = 2;

   frs_pkg::cmd_type slot_ff [Slots];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             known;
   logic             push;
   logic             pop;
   frs_pkg::cmd_type decoded;

   always_comb begin
      known             = 1'b1;
      decoded.kind      = frs_pkg::CMD_ENQUEUE;
      decoded.frame_id  = req_item.frame_id;
      decoded.stamp     = {1'b0, req_item.time_us};
      case (req_item.op)
         frs_pkg::OP_ENQUEUE: decoded.kind = frs_pkg::CMD_ENQUEUE;
         frs_pkg::OP_TICK: begin
            decoded.kind  = frs_pkg::CMD_TICK;
            decoded.stamp = {1'b0, req_item.time_us} +
                            frs_pkg::STAMP_WIDTH'(timing.offset);
         end
         frs_pkg::OP_FLUSH:   decoded.kind = frs_pkg::CMD_FLUSH;
         frs_pkg::OP_PAUSE:   decoded.kind = frs_pkg::CMD_PAUSE;
         frs_pkg::OP_RESUME:  decoded.kind = frs_pkg::CMD_RESUME;
         default:             known        = 1'b0;
      endcase
   end

   assign req_ready = !timing.busy && (fill_ff != 2'd2);
   assign push      = req_valid && req_ready && known;
   assign pop       = cmd_pop && cmd_valid;
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

>>> src/frs_back.sv
// ----------------------------------------------------------------------------
// frs_back
// Frame queue, pause flag and release sequencer; drives the item register
// of the result channel.
// ----------------------------------------------------------------------------
module frs_back #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  frs_pkg::cmd_type  cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output frs_pkg::rsp_type  rsp_item
);

   localparam int IndexWidth = $clog2(QUEUE_DEPTH);
   localparam int CountWidth = $clog2(QUEUE_DEPTH + 1);
   localparam int EntryWidth = frs_pkg::ID_WIDTH + frs_pkg::TIME_WIDTH;
   localparam logic [IndexWidth-1:0] LastIndex = IndexWidth'(QUEUE_DEPTH - 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(QUEUE_DEPTH);
   localparam logic [CountWidth-1:0] OneCount  = CountWidth'(1);

   frs_pkg::back_state_type               state_ff, state_in;
   logic [IndexWidth-1:0]                 head_ff, head_in;
   logic [IndexWidth-1:0]                 tail_ff, tail_in;
   logic [CountWidth-1:0]                 count_ff, count_in;
   logic                                  paused_ff, paused_in;
   logic                                  have_ff, have_in;
   logic [frs_pkg::ID_WIDTH-1:0]          held_ff, held_in;
   logic [frs_pkg::POP_COUNT_WIDTH-1:0]   pops_ff, pops_in;
   logic [frs_pkg::STAMP_WIDTH-1:0]       deadline_ff, deadline_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   frs_pkg::rsp_type                      rsp_ff, rsp_in;

   logic                                  wr_en;
   logic [EntryWidth-1:0]                 rd_data;
   logic [frs_pkg::ID_WIDTH-1:0]          rd_id;
   logic [frs_pkg::TIME_WIDTH-1:0]        rd_time;
   logic                                  can_emit;
   logic                                  emit;
   frs_pkg::rsp_type                      emit_item;
   logic                                  due;
   logic                                  flush_last;

   frs_ram #(
      .WIDTH (EntryWidth),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data ({cmd.frame_id, cmd.stamp[frs_pkg::TIME_WIDTH-1:0]}),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   assign rd_id      = rd_data[EntryWidth-1:frs_pkg::TIME_WIDTH];
   assign rd_time    = rd_data[frs_pkg::TIME_WIDTH-1:0];
   assign can_emit   = !rsp_valid_ff || rsp_ready;
   assign due        = !(deadline_ff < {1'b0, rd_time});
   assign flush_last = (count_ff == OneCount) || (pops_ff == frs_pkg::POP_LAST);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      paused_in    = paused_ff;
      have_in      = have_ff;
      held_in      = held_ff;
      pops_in      = pops_ff;
      deadline_in  = deadline_ff;
      cmd_pop      = 1'b0;
      wr_en        = 1'b0;
      emit         = 1'b0;
      emit_item    = '{action: frs_pkg::ACT_DROP, frame_id_out: held_ff, last: 1'b0};

      case (state_ff)
         frs_pkg::BK_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  frs_pkg::CMD_ENQUEUE: begin
                     if (count_ff == FullCount) begin
                        if (can_emit) begin
                           emit      = 1'b1;
                           emit_item = '{action: frs_pkg::ACT_REJECT,
                                         frame_id_out: cmd.frame_id, last: 1'b1};
                           cmd_pop   = 1'b1;
                        end
                     end else begin
                        wr_en    = 1'b1;
                        tail_in  = (tail_ff == LastIndex) ? '0 : tail_ff + 1'b1;
                        count_in = count_ff + 1'b1;
                        cmd_pop  = 1'b1;
                     end
                  end
                  frs_pkg::CMD_TICK: begin
                     cmd_pop     = 1'b1;
                     deadline_in = cmd.stamp;
                     have_in     = 1'b0;
                     pops_in     = '0;
                     if (!paused_ff) begin
                        state_in = frs_pkg::BK_TICK_READ;
                     end
                  end
                  frs_pkg::CMD_FLUSH: begin
                     cmd_pop  = 1'b1;
                     pops_in  = '0;
                     state_in = frs_pkg::BK_FLUSH_READ;
                  end
                  frs_pkg::CMD_PAUSE: begin
                     cmd_pop   = 1'b1;
                     paused_in = 1'b1;
                  end
                  frs_pkg::CMD_RESUME: begin
                     cmd_pop   = 1'b1;
                     paused_in = 1'b0;
                  end
                  default: cmd_pop = 1'b1;
               endcase
            end
         end
         frs_pkg::BK_TICK_READ: begin
            if (count_ff == '0) begin
               state_in = have_ff ? frs_pkg::BK_TICK_POST : frs_pkg::BK_IDLE;
            end else begin
               state_in = frs_pkg::BK_TICK_CHECK;
            end
         end
         frs_pkg::BK_TICK_CHECK: begin
            if (!due) begin
               state_in = have_ff ? frs_pkg::BK_TICK_POST : frs_pkg::BK_IDLE;
            end else if (!have_ff || can_emit) begin
               emit     = have_ff;
               held_in  = rd_id;
               have_in  = 1'b1;
               head_in  = (head_ff == LastIndex) ? '0 : head_ff + 1'b1;
               count_in = count_ff - 1'b1;
               pops_in  = pops_ff + 1'b1;
               state_in = (pops_ff == frs_pkg::POP_LAST) ? frs_pkg::BK_TICK_POST
                                                          : frs_pkg::BK_TICK_READ;
            end
         end
         frs_pkg::BK_TICK_POST: begin
            if (can_emit) begin
               emit      = 1'b1;
               emit_item = '{action: frs_pkg::ACT_POST, frame_id_out: held_ff, last: 1'b1};
               have_in   = 1'b0;
               state_in  = frs_pkg::BK_IDLE;
            end
         end
         frs_pkg::BK_FLUSH_READ: begin
            state_in = (count_ff == '0) ? frs_pkg::BK_IDLE : frs_pkg::BK_FLUSH_EMIT;
         end
         frs_pkg::BK_FLUSH_EMIT: begin
            if (can_emit) begin
               emit      = 1'b1;
               emit_item = '{action: frs_pkg::ACT_DROP, frame_id_out: rd_id, last: flush_last};
               head_in   = (head_ff == LastIndex) ? '0 : head_ff + 1'b1;
               count_in  = count_ff - 1'b1;
               pops_in   = pops_ff + 1'b1;
               state_in  = flush_last ? frs_pkg::BK_IDLE : frs_pkg::BK_FLUSH_READ;
            end
         end
         default: state_in = frs_pkg::BK_IDLE;
      endcase

      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_in       = emit ? emit_item : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= frs_pkg::BK_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         paused_ff    <= 1'b0;
         have_ff      <= 1'b0;
         pops_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         paused_ff    <= paused_in;
         have_ff      <= have_in;
         pops_ff      <= pops_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      held_ff     <= held_in;
      deadline_ff <= deadline_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCount)
      else $error("frame count exceeds queue depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty queue with unequal pointers");

   a_held_tracks_pops: assert property (@(posedge clock) disable iff (reset)
      (state_ff == frs_pkg::BK_TICK_CHECK) |-> (have_ff == (pops_ff != '0)))
      else $error("held frame flag out of step with pop count");

   a_post_has_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == frs_pkg::BK_TICK_POST) |-> have_ff)
      else $error("post without a held frame");

   a_post_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.action == frs_pkg::ACT_POST)) |-> rsp_ff.last)
      else $error("post item not marked last");
`endif

endmodule

>>> src/vblank_frame_release_scheduler.sv
// ----------------------------------------------------------------------------
// vblank_frame_release_scheduler
// Frame queue released on vblank ticks against a deadline of the tick time
// plus lead_vblanks refresh intervals.
// ----------------------------------------------------------------------------
// The back end takes accepted items from a two-entry command queue in its idle state,
// which handles enqueue, reject, pause and resume; per frame a flush runs FLUSH_READ
// and FLUSH_EMIT, a tick TICK_READ and TICK_CHECK, then TICK_POST (registered store
// read port). A nonzero refresh_hz write holds csr_ready low while the bit-serial
// divider runs; it and a lead_vblanks write hold req_ready low until the offset settles.
// Reset: synchronous; queue empty, not paused, refresh_hz 60, lead_vblanks 3.
module vblank_frame_release_scheduler #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  frs_pkg::req_type                     req_item,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output frs_pkg::rsp_type                     rsp_item,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [frs_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [frs_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);

   frs_pkg::timing_type timing;
   logic                cmd_valid;
   frs_pkg::cmd_type    cmd;
   logic                cmd_pop;

   frs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .timing    (timing)
   );

   frs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .timing    (timing),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   frs_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

>>> sim/tb_vblank_frame_release_scheduler.sv
// ----------------------------------------------------------------------------
// tb_vblank_frame_release_scheduler
// Self-checking bench for the vblank frame release scheduler. Drives enqueue,
// tick, flush, pause and resume items plus register writes, keeps its own
// frame queue and deadline arithmetic, and compares every drop, post and
// reject result in order against the predicted stream.
// ----------------------------------------------------------------------------
module tb_vblank_frame_release_scheduler;

   localparam int FRAME_SLOTS     = 16;
   localparam int SETTLE_CYCLES   = 8;
   localparam int IDLE_LIMIT      = 3000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int REPORT_LIMIT    = 10;
   localparam int PHASE_ITEMS     = 34;

   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_MID   = 3'd6;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
   localparam logic [frs_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [frs_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE_HIGH = 2'd3;
   localparam logic [frs_pkg::TIME_WIDTH-1:0] TIME_MAX = '1;

   typedef enum int {
      STALL_NONE,
      STALL_SPARSE,
      STALL_PERIODIC,
      STALL_COIN
   } stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   frs_pkg::req_type req_item = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   frs_pkg::rsp_type rsp_item;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [frs_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [frs_pkg::CSR_DATA_WIDTH-1:0] csr_data = '0;

   logic [frs_pkg::ID_WIDTH-1:0] queued_frame_ids[$];
   logic [frs_pkg::TIME_WIDTH-1:0] queued_frame_times[$];
   logic frames_paused = 1'b0;
   logic [frs_pkg::HZ_WIDTH-1:0] hz_setting = frs_pkg::REFRESH_HZ_RESET;
   logic [frs_pkg::LEAD_WIDTH-1:0] lead_setting = frs_pkg::LEAD_RESET;
   frs_pkg::rsp_type expected_actions[$];

   int mismatch_count = 0;
   int idle_cycles = 0;
   int burst_left = 0;

   int rsp_hold_trigger = 0;
   int rsp_hold_seen = 0;
   int rsp_hold_left = 0;
   int rsp_pattern_step = 0;
   stall_mode_type rsp_stall_mode = STALL_NONE;

   vblank_frame_release_scheduler #(
      .QUEUE_DEPTH(FRAME_SLOTS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [frs_pkg::STAMP_WIDTH-1:0] release_deadline(
      input logic [frs_pkg::TIME_WIDTH-1:0] stamp
   );
      logic [frs_pkg::STAMP_WIDTH-1:0] interval;
      interval = '0;
      if (hz_setting != '0)
         interval = (frs_pkg::STAMP_WIDTH'(frs_pkg::UsecPerSecInt)
                     + frs_pkg::STAMP_WIDTH'(hz_setting / 2))
                    / frs_pkg::STAMP_WIDTH'(hz_setting);
      return frs_pkg::STAMP_WIDTH'(stamp) + frs_pkg::STAMP_WIDTH'(lead_setting) * interval;
   endfunction

   function automatic void apply_frame_request(input frs_pkg::req_type item);
      logic [frs_pkg::STAMP_WIDTH-1:0] deadline;
      logic [frs_pkg::ID_WIDTH-1:0] released_ids[$];
      logic post_final;
      frs_pkg::rsp_type r;
      post_final = 1'b0;
      case (item.op)
         frs_pkg::OP_ENQUEUE: begin
            if (queued_frame_ids.size() >= FRAME_SLOTS) begin
               r.action = frs_pkg::ACT_REJECT;
               r.frame_id_out = item.frame_id;
               r.last = 1'b1;
               expected_actions.push_back(r);
            end else begin
               queued_frame_ids.push_back(item.frame_id);
               queued_frame_times.push_back(item.time_us);
            end
         end
         frs_pkg::OP_TICK: begin
            deadline = release_deadline(item.time_us);
            post_final = 1'b1;
            while (!frames_paused && queued_frame_ids.size() > 0
                   && released_ids.size() < frs_pkg::MAX_RESULTS
                   && frs_pkg::STAMP_WIDTH'(queued_frame_times[0]) <= deadline) begin
               void'(queued_frame_times.pop_front());
               released_ids.push_back(queued_frame_ids.pop_front());
            end
         end
         frs_pkg::OP_FLUSH: begin
            while (queued_frame_ids.size() > 0
                   && released_ids.size() < frs_pkg::MAX_RESULTS) begin
               void'(queued_frame_times.pop_front());
               released_ids.push_back(queued_frame_ids.pop_front());
            end
         end
         frs_pkg::OP_PAUSE: frames_paused = 1'b1;
         frs_pkg::OP_RESUME: frames_paused = 1'b0;
         default: ;
      endcase
      foreach (released_ids[k]) begin
         r.action = (post_final && k == released_ids.size() - 1) ? frs_pkg::ACT_POST
                                                                  : frs_pkg::ACT_DROP;
         r.frame_id_out = released_ids[k];
         r.last = (k == released_ids.size() - 1);
         expected_actions.push_back(r);
      end
   endfunction

   function automatic frs_pkg::req_type make_request(
      input logic [2:0]                     op,
      input logic [frs_pkg::ID_WIDTH-1:0]   frame_id,
      input logic [frs_pkg::TIME_WIDTH-1:0] stamp
   );
      frs_pkg::req_type item;
      item.op = op;
      item.frame_id = frame_id;
      item.time_us = stamp;
      return item;
   endfunction

   function automatic void report_mismatch(
      input string what, input frs_pkg::rsp_type want, input frs_pkg::rsp_type got
   );
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t %s: expected action %0d id %h last %b, got action %0d id %h last %b",
                  $time, what, want.action, want.frame_id_out, want.last,
                  got.action, got.frame_id_out, got.last);
   endfunction

   task automatic send_request(input frs_pkg::req_type item);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
      end
      req_valid <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_frame_request(item);
      burst_left--;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (expected_actions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(
      input logic [frs_pkg::CSR_INDEX_WIDTH-1:0] index,
      input logic [frs_pkg::CSR_DATA_WIDTH-1:0]  data
   );
      wait_for_drain();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (index == frs_pkg::CSR_REFRESH_HZ)
         hz_setting = data;
      else if (index == frs_pkg::CSR_LEAD_VBLANKS)
         lead_setting = data[frs_pkg::LEAD_WIDTH-1:0];
   endtask

   task automatic test_release_deadline();
      send_request(make_request(frs_pkg::OP_ENQUEUE, 16'h0000, 63'd0));
      send_request(make_request(frs_pkg::OP_ENQUEUE, 16'hFFFF, 63'd100));
      send_request(make_request(frs_pkg::OP_ENQUEUE, 16'h1234, 63'd51001));
      send_request(make_request(frs_pkg::OP_ENQUEUE, 16'h4321, 63'd51002));
      send_request(make_request(frs_pkg::OP_TICK, 16'h0000, 63'd1000));
      send_request(make_request(frs_pkg::OP_TICK, 16'hFFFF, 63'd1001));
      send_request(make_request(frs_pkg::OP_TICK, 16'h0000, 63'd2000));
   endtask

   task automatic test_pause_and_flush();
      send_request(make_request(frs_pkg::OP_ENQUEUE, 16'h0001, 63'd0));
      send_request(make_request(frs_pkg::OP_PAUSE, 16'h0000, 63'd0));
      send_request(make_request(frs_pkg::OP_TICK, 16'h0000, 63'd1000));
      send_request(make_request(frs_pkg::OP_ENQUEUE, 16'h0002, 63'd5));
      send_request(make_request(frs_pkg::OP_FLUSH, 16'h0000, 63'd0));
      send_request(make_request(frs_pkg::OP_FLUSH, 16'h0000, 63'd0));
      send_request(make_request(frs_pkg::OP_RESUME, 16'h0000, 63'd0));
      send_request(make_request(OP_SPARE_FIRST, 16'($urandom), TIME_MAX));
      send_request(make_request(OP_SPARE_MID, 16'($urandom), 63'({$urandom, $urandom})));
      send_request(make_request(OP_SPARE_LAST, 16'hFFFF, TIME_MAX));
      send_request(make_request(frs_pkg::OP_ENQUEUE, 16'h5A5A, 63'd1000000));
      send_request(make_request(frs_pkg::OP_TICK, 16'h0000, 63'd0));
      send_request(make_request(frs_pkg::OP_FLUSH, 16'h0000, 63'd0));
   endtask

   task automatic test_wide_deadline();
      send_request(make_request(frs_pkg::OP_ENQUEUE, 16'hA5A5, TIME_MAX));
      send_request(make_request(frs_pkg::OP_TICK, 16'h5A5A, TIME_MAX));
   endtask

   task automatic test_full_queue();
      for (int k = 0; k < FRAME_SLOTS; k++)
         send_request(make_request(frs_pkg::OP_ENQUEUE, 16'(k * 4097), 63'(k * 1000)));
      send_request(make_request(frs_pkg::OP_ENQUEUE, 16'hBEEF, 63'($urandom)));
      send_request(make_request(frs_pkg::OP_ENQUEUE, 16'h0F0F, TIME_MAX));
      send_request(make_request(frs_pkg::OP_TICK, 16'h0000, TIME_MAX));
      for (int k = 0; k < FRAME_SLOTS; k++)
         send_request(make_request(frs_pkg::OP_ENQUEUE, 16'($urandom),
                                   63'({$urandom, $urandom})));
      send_request(make_request(frs_pkg::OP_FLUSH, 16'h0000, 63'd0));
   endtask

   task automatic test_register_extremes();
      write_register(frs_pkg::CSR_REFRESH_HZ, 8'd0);
      write_register(frs_pkg::CSR_LEAD_VBLANKS, 8'hFF);
      send_request(make_request(frs_pkg::OP_ENQUEUE, 16'h0100, 63'd5000));
      send_request(make_request(frs_pkg::OP_ENQUEUE, 16'h0101, 63'd5001));
      send_request(make_request(frs_pkg::OP_TICK, 16'h0000, 63'd5000));
      send_request(make_request(frs_pkg::OP_TICK, 16'h0000, 63'd5001));
      write_register(frs_pkg::CSR_REFRESH_HZ, 8'd240);
      write_register(frs_pkg::CSR_LEAD_VBLANKS, 8'h08);
      send_request(make_request(frs_pkg::OP_ENQUEUE, 16'h0200, 63'd10));
      send_request(make_request(frs_pkg::OP_TICK, 16'h0000, 63'd9));
      send_request(make_request(frs_pkg::OP_TICK, 16'h0000, 63'd10));
      write_register(frs_pkg::CSR_REFRESH_HZ, 8'd1);
      write_register(frs_pkg::CSR_LEAD_VBLANKS, 8'd7);
      send_request(make_request(frs_pkg::OP_ENQUEUE, 16'h0300, 63'd7000000));
      send_request(make_request(frs_pkg::OP_ENQUEUE, 16'h0301, 63'd7000001));
      send_request(make_request(frs_pkg::OP_TICK, 16'h0000, 63'd0));
      send_request(make_request(frs_pkg::OP_FLUSH, 16'h0000, 63'd0));
      write_register(frs_pkg::CSR_REFRESH_HZ, 8'd255);
      write_register(frs_pkg::CSR_LEAD_VBLANKS, 8'd1);
      send_request(make_request(frs_pkg::OP_ENQUEUE, 16'h0400, 63'd3922));
      send_request(make_request(frs_pkg::OP_TICK, 16'h0000, 63'd0));
      write_register(CSR_SPARE_LOW, 8'hFF);
      write_register(CSR_SPARE_HIGH, 8'hFF);
      send_request(make_request(frs_pkg::OP_ENQUEUE, 16'h0401, 63'd3923));
      send_request(make_request(frs_pkg::OP_TICK, 16'h0000, 63'd0));
      send_request(make_request(frs_pkg::OP_TICK, 16'h0000, 63'd1));
      write_register(frs_pkg::CSR_REFRESH_HZ, frs_pkg::REFRESH_HZ_RESET);
      write_register(frs_pkg::CSR_LEAD_VBLANKS, 8'(frs_pkg::LEAD_RESET));
   endtask

   task automatic test_output_backpressure();
      for (int k = 0; k < FRAME_SLOTS; k++)
         send_request(make_request(frs_pkg::OP_ENQUEUE, 16'($urandom), TIME_MAX - 63'(k)));
      rsp_hold_trigger <= rsp_hold_trigger + 1;
      for (int k = 0; k < 40; k++)
         send_request(make_request(frs_pkg::OP_ENQUEUE, 16'($urandom),
                                   63'({$urandom, $urandom})));
      send_request(make_request(frs_pkg::OP_FLUSH, 16'h0000, 63'd0));
      wait_for_drain();
   endtask

   task automatic run_random_phase(input logic [frs_pkg::TIME_WIDTH-1:0] base);
      logic [frs_pkg::TIME_WIDTH-1:0] now_us;
      logic [frs_pkg::STAMP_WIDTH-1:0] window;
      frs_pkg::req_type item;
      int pick;
      now_us = base;
      window = release_deadline('0) + 64'd5000;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         item = make_request(frs_pkg::OP_ENQUEUE, 16'($urandom), 63'({$urandom, $urandom}));
         if (pick < 45) begin
            item.time_us = now_us
                           + frs_pkg::TIME_WIDTH'($urandom_range(0, 32'(2 * window)));
         end else if (pick < 75) begin
            item.op = frs_pkg::OP_TICK;
            item.time_us = now_us;
            now_us = now_us + frs_pkg::TIME_WIDTH'($urandom_range(0, 32'(window / 2)));
         end else if (pick < 80) begin
            item.op = frs_pkg::OP_FLUSH;
         end else if (pick < 85) begin
            item.op = frs_pkg::OP_PAUSE;
         end else if (pick < 93) begin
            item.op = frs_pkg::OP_RESUME;
         end else begin
            item.op = 3'($urandom_range(0, 7));
         end
         send_request(item);
      end
   endtask

   task automatic test_random_traffic();
      logic [frs_pkg::TIME_WIDTH-1:0] base;
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin
               write_register(frs_pkg::CSR_REFRESH_HZ, 8'd60);
               write_register(frs_pkg::CSR_LEAD_VBLANKS, 8'd3);
            end
            1: begin
               write_register(frs_pkg::CSR_REFRESH_HZ, 8'd0);
               write_register(frs_pkg::CSR_LEAD_VBLANKS, 8'd7);
            end
            2: begin
               write_register(frs_pkg::CSR_REFRESH_HZ, 8'd240);
               write_register(frs_pkg::CSR_LEAD_VBLANKS, 8'd0);
            end
            3: begin
               write_register(frs_pkg::CSR_REFRESH_HZ, 8'd1);
               write_register(frs_pkg::CSR_LEAD_VBLANKS, 8'd7);
            end
            4: begin
               write_register(frs_pkg::CSR_REFRESH_HZ, 8'd255);
               write_register(frs_pkg::CSR_LEAD_VBLANKS, 8'd2);
            end
            default: begin
               write_register(frs_pkg::CSR_REFRESH_HZ, 8'($urandom));
               write_register(frs_pkg::CSR_LEAD_VBLANKS, 8'($urandom));
            end
         endcase
         base = (p % 2 == 0) ? 63'($urandom)
                             : TIME_MAX - 63'($urandom_range(0, 1000000));
         run_random_phase(base);
      end
   endtask

   always @(posedge clock) begin
      rsp_pattern_step <= rsp_pattern_step + 1;
      if (rsp_pattern_step % 97 == 0)
         rsp_stall_mode <= stall_mode_type'($urandom_range(0, 3));
      if (rsp_hold_seen != rsp_hold_trigger) begin
         rsp_hold_seen <= rsp_hold_trigger;
         rsp_hold_left <= HOLD_OFF_CYCLES;
         rsp_ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         case (rsp_stall_mode)
            STALL_NONE: rsp_ready <= 1'b1;
            STALL_SPARSE: rsp_ready <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: rsp_ready <= (rsp_pattern_step % 5 < 2);
            default: rsp_ready <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   always @(posedge clock) begin : action_check
      frs_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_actions.size() == 0) begin
            report_mismatch("unexpected result", '0, rsp_item);
         end else begin
            want = expected_actions.pop_front();
            if (rsp_item.action !== want.action
                || rsp_item.frame_id_out !== want.frame_id_out
                || rsp_item.last !== want.last)
               report_mismatch("wrong result", want, rsp_item);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_release_deadline();
      test_pause_and_flush();
      test_wide_deadline();
      test_full_queue();
      test_register_extremes();
      test_output_backpressure();
      test_random_traffic();
      wait_for_drain();
      repeat (4 * SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_actions.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

>>> filelist.f
src/frs_pkg.sv
src/frs_ram.sv
src/frs_csr.sv
src/frs_front.sv
src/frs_back.sv
src/vblank_frame_release_scheduler.sv
sim/tb_vblank_frame_release_scheduler.sv
